[hw/rtl/cbps_pkg.sv]
// ----------------------------------------------------------------------------
// cbps_pkg
// Shared types, register map and microcode program of the cubic Bezier
// path stepper.
// ----------------------------------------------------------------------------
package cbps_pkg;

  localparam int PT_W       = 48;
  localparam int CFG_AW     = 6;
  localparam int CFG_DW     = 64;
  localparam int STEP_RESET = 131;
  localparam int STEP_W     = 4;

  // register indexes, taken from paddr[5:3]
  localparam logic [2:0] REG_START_POINT   = 3'd0;
  localparam logic [2:0] REG_FIRST_HANDLE  = 3'd1;
  localparam logic [2:0] REG_SECOND_HANDLE = 3'd2;
  localparam logic [2:0] REG_END_POINT     = 3'd3;
  localparam logic [2:0] REG_PARAM_STEP    = 3'd4;

  localparam logic [1:0] AXIS_LAST = 2'd2;
  localparam logic [STEP_W-1:0] LOOP_STEP = 4'd6;

  typedef enum logic {
    SQ_IDLE,
    SQ_RUN
  } seq_state_t;

  // multiplier operand a (unsigned)
  typedef enum logic [2:0] {
    OPA_T,
    OPA_U,
    OPA_T2,
    OPA_U2,
    OPA_W0,
    OPA_W1,
    OPA_W2,
    OPA_W3
  } opa_t;

  // multiplier operand b (signed)
  typedef enum logic [2:0] {
    OPB_T,
    OPB_U,
    OPB_P0,
    OPB_P1,
    OPB_P2,
    OPB_P3
  } opb_t;

  // where the registered product is written, in the cycle after its step
  typedef enum logic [3:0] {
    DST_NONE,
    DST_T2,
    DST_U2,
    DST_T3,
    DST_U3,
    DST_W1,
    DST_W2,
    DST_ACC_FIRST,
    DST_ACC_ADD,
    DST_ACC_LAST
  } dst_t;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_AXIS,
    BR_EMIT
  } br_t;

  typedef struct packed {
    opa_t             opa;
    opb_t             opb;
    dst_t             dst;
    br_t              br;
    logic [STEP_W-1:0] tgt;
  } uword_t;

  typedef struct packed {
    logic       start;
    logic       emit;
    opa_t       opa;
    opb_t       opb;
    dst_t       dst;
    logic [1:0] axis;
  } dp_ctrl_t;

  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] pc);
    uword_t w;
    w = '{opa: OPA_T, opb: OPB_T, dst: DST_NONE, br: BR_NEXT, tgt: '0};
    unique case (pc)
      4'd0: begin
        w.opa = OPA_T;  w.opb = OPB_T;  w.dst = DST_T2;
      end
      4'd1: begin
        w.opa = OPA_U;  w.opb = OPB_U;  w.dst = DST_U2;
      end
      4'd2: begin
        w.opa = OPA_T2; w.opb = OPB_T;  w.dst = DST_T3;
      end
      4'd3: begin
        w.opa = OPA_U2; w.opb = OPB_U;  w.dst = DST_U3;
      end
      4'd4: begin
        w.opa = OPA_U2; w.opb = OPB_T;  w.dst = DST_W1;
      end
      4'd5: begin
        w.opa = OPA_T2; w.opb = OPB_U;  w.dst = DST_W2;
      end
      4'd6: begin
        w.opa = OPA_W0; w.opb = OPB_P0; w.dst = DST_ACC_FIRST;
      end
      4'd7: begin
        w.opa = OPA_W1; w.opb = OPB_P1; w.dst = DST_ACC_ADD;
      end
      4'd8: begin
        w.opa = OPA_W2; w.opb = OPB_P2; w.dst = DST_ACC_ADD;
      end
      4'd9: begin
        w.opa = OPA_W3; w.opb = OPB_P3; w.dst = DST_ACC_LAST;
        w.br  = BR_AXIS; w.tgt = LOOP_STEP;
      end
      4'd10: begin
        // drain the last accumulate
        w.br = BR_NEXT;
      end
      default: begin
        w.br = BR_EMIT;
      end
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/cbps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// cbps_cfg_regs
// APB register file: four control points and the parameter step.
// ----------------------------------------------------------------------------
module cbps_cfg_regs #(
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [cbps_pkg::CFG_AW-1:0]          cfg_paddr,
  input  logic [cbps_pkg::CFG_DW-1:0]          cfg_pwdata,
  output logic [cbps_pkg::CFG_DW-1:0]          cfg_prdata,
  output logic                                 cfg_pready,
  output logic [3:0][cbps_pkg::PT_W-1:0]       points_o,
  output logic [PARAM_FRAC_BITS:0]             step_o
);
  import cbps_pkg::*;

  localparam int PW = PARAM_FRAC_BITS + 1;

  logic [3:0][PT_W-1:0] points_r;
  logic [PW-1:0]        step_r;
  logic [2:0]           idx;
  logic                 wr_en;

  assign idx        = cfg_paddr[CFG_AW-1:3];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= '0;
      step_r   <= PW'(STEP_RESET);
    end else if (wr_en) begin
      unique case (idx)
        REG_START_POINT:   points_r[0] <= cfg_pwdata[PT_W-1:0];
        REG_FIRST_HANDLE:  points_r[1] <= cfg_pwdata[PT_W-1:0];
        REG_SECOND_HANDLE: points_r[2] <= cfg_pwdata[PT_W-1:0];
        REG_END_POINT:     points_r[3] <= cfg_pwdata[PT_W-1:0];
        REG_PARAM_STEP:    step_r      <= cfg_pwdata[PW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_START_POINT:   cfg_prdata = CFG_DW'(points_r[0]);
      REG_FIRST_HANDLE:  cfg_prdata = CFG_DW'(points_r[1]);
      REG_SECOND_HANDLE: cfg_prdata = CFG_DW'(points_r[2]);
      REG_END_POINT:     cfg_prdata = CFG_DW'(points_r[3]);
      REG_PARAM_STEP:    cfg_prdata = CFG_DW'(step_r);
      default:           cfg_prdata = '0;
    endcase
  end

  assign points_o = points_r;
  assign step_o   = step_r;

endmodule

[hw/rtl/cbps_useq.sv]
// ----------------------------------------------------------------------------
// cbps_useq
// Microcode sequencer: step counter, axis loop counter and branch logic
// over the program held in the package.
// ----------------------------------------------------------------------------
module cbps_useq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_free_i,
  output cbps_pkg::dp_ctrl_t ctrl_o
);
  import cbps_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] pc_r, pc_nxt;
  logic [1:0]        axis_r, axis_nxt;
  uword_t            uw;

  assign uw = ucode_rom(pc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      pc_r    <= '0;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SQ_IDLE: if (in_valid_i) state_nxt = SQ_RUN;
      SQ_RUN:  if (uw.br == BR_EMIT && out_free_i) state_nxt = SQ_IDLE;
    endcase
  end

  always_comb begin
    pc_nxt       = pc_r;
    axis_nxt     = axis_r;
    in_ready_o   = 1'b0;
    ctrl_o.start = 1'b0;
    ctrl_o.emit  = 1'b0;
    ctrl_o.opa   = uw.opa;
    ctrl_o.opb   = uw.opb;
    ctrl_o.dst   = DST_NONE;
    ctrl_o.axis  = axis_r;
    unique case (state_r)
      SQ_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.start = 1'b1;
          pc_nxt       = '0;
          axis_nxt     = '0;
        end
      end
      SQ_RUN: begin
        ctrl_o.dst = uw.dst;
        unique case (uw.br)
          BR_NEXT: pc_nxt = pc_r + 1'b1;
          BR_AXIS: begin
            // loop over x, y, z
            if (axis_r == AXIS_LAST) begin
              axis_nxt = '0;
              pc_nxt   = pc_r + 1'b1;
            end else begin
              axis_nxt = axis_r + 1'b1;
              pc_nxt   = uw.tgt;
            end
          end
          BR_EMIT: ctrl_o.emit = out_free_i;
          default: pc_nxt = pc_r;
        endcase
      end
    endcase
  end

endmodule

[hw/rtl/cbps_datapath.sv]
// ----------------------------------------------------------------------------
// cbps_datapath
// Parameter register, shared multiplier with product register, weight
// registers, accumulator with round and saturate, and the output register.
// ----------------------------------------------------------------------------
module cbps_datapath #(
  parameter int COORD_WIDTH     = 16,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cbps_pkg::dp_ctrl_t              ctrl_i,
  input  logic                            cmd_i,
  input  logic [PARAM_FRAC_BITS+2:0]      new_param_i,
  input  logic [3:0][cbps_pkg::PT_W-1:0]  points_i,
  input  logic [PARAM_FRAC_BITS:0]        step_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic                            out_free_o,
  output logic [COORD_WIDTH-1:0]          pos_x_o,
  output logic [COORD_WIDTH-1:0]          pos_y_o,
  output logic [COORD_WIDTH-1:0]          pos_z_o,
  output logic [PARAM_FRAC_BITS:0]        param_o
);
  import cbps_pkg::*;

  localparam int PW     = PARAM_FRAC_BITS + 1;
  localparam int LW     = PARAM_FRAC_BITS + 3;
  localparam int MA_W   = PW + 2;
  localparam int MB_W   = (COORD_WIDTH > PW) ? COORD_WIDTH : PW + 1;
  localparam int PROD_W = MA_W + 1 + MB_W;
  localparam int ACC_W  = PROD_W + 2;

  localparam logic [PW-1:0] ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};
  localparam logic signed [PROD_W-1:0] HALF_P =
    {{(PROD_W-PARAM_FRAC_BITS){1'b0}}, 1'b1, {(PARAM_FRAC_BITS-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] HALF_A =
    {{(ACC_W-PARAM_FRAC_BITS){1'b0}}, 1'b1, {(PARAM_FRAC_BITS-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  logic signed [COORD_WIDTH-1:0] coord_w [4][3];

  // coordinate fields; a field starting past bit 63 reads as zero
  for (genvar p = 0; p < 4; p++) begin : g_pt
    for (genvar a = 0; a < 3; a++) begin : g_ax
      if (a * COORD_WIDTH >= 64) begin : g_zero
        assign coord_w[p][a] = '0;
      end else begin : g_fld
        logic [63:0] sh_w;
        assign sh_w          = 64'(points_i[p]) >> (a * COORD_WIDTH);
        assign coord_w[p][a] = sh_w[COORD_WIDTH-1:0];
      end
    end
  end

  logic [PW-1:0]   t_r, t2_r, u2_r, t3_r, u3_r;
  logic [MA_W-1:0] w1_r, w2_r;
  logic signed [PROD_W-1:0] prod_r;
  dst_t            dst_r;
  logic [1:0]      axis_d_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [COORD_WIDTH-1:0]   pos_r [3];
  logic [COORD_WIDTH-1:0]   out_x_r, out_y_r, out_z_r;
  logic [PW-1:0]   out_t_r;
  logic            out_valid_r;

  logic [PW-1:0]   u_w, t_nxt;
  logic [PW:0]     tick_sum;
  logic [MA_W-1:0] a_op;
  logic signed [MB_W-1:0]   b_op;
  logic signed [PROD_W-1:0] prod_w, rnd_full;
  logic [PW-1:0]   rnd_q;
  logic [MA_W-1:0] rnd_x3;
  logic signed [ACC_W-1:0]  acc_sum, q_w;
  logic [COORD_WIDTH-1:0]   sat_w;

  assign u_w      = ONE - t_r;
  assign tick_sum = {1'b0, t_r} + {1'b0, step_i};

  always_comb begin
    if (cmd_i) begin
      if (new_param_i[LW-1])
        t_nxt = '0;
      else if (new_param_i > {2'b00, ONE})
        t_nxt = ONE;
      else
        t_nxt = new_param_i[PW-1:0];
    end else begin
      // past one wraps to zero, exactly one is kept
      t_nxt = (tick_sum > {1'b0, ONE}) ? '0 : tick_sum[PW-1:0];
    end
  end

  always_comb begin
    unique case (ctrl_i.opa)
      OPA_T:  a_op = MA_W'(t_r);
      OPA_U:  a_op = MA_W'(u_w);
      OPA_T2: a_op = MA_W'(t2_r);
      OPA_U2: a_op = MA_W'(u2_r);
      OPA_W0: a_op = MA_W'(u3_r);
      OPA_W1: a_op = w1_r;
      OPA_W2: a_op = w2_r;
      OPA_W3: a_op = MA_W'(t3_r);
    endcase
  end

  always_comb begin
    unique case (ctrl_i.opb)
      OPB_T:   b_op = MB_W'(t_r);
      OPB_U:   b_op = MB_W'(u_w);
      OPB_P0:  b_op = MB_W'(coord_w[0][ctrl_i.axis]);
      OPB_P1:  b_op = MB_W'(coord_w[1][ctrl_i.axis]);
      OPB_P2:  b_op = MB_W'(coord_w[2][ctrl_i.axis]);
      OPB_P3:  b_op = MB_W'(coord_w[3][ctrl_i.axis]);
      default: b_op = '0;
    endcase
  end

  assign prod_w = $signed({1'b0, a_op}) * b_op;

  assign rnd_full = prod_r + HALF_P;
  assign rnd_q    = rnd_full[PARAM_FRAC_BITS +: PW];
  assign rnd_x3   = MA_W'({rnd_q, 1'b0}) + MA_W'(rnd_q);

  assign acc_sum = acc_r + ACC_W'(prod_r);
  assign q_w     = acc_sum >>> PARAM_FRAC_BITS;

  always_comb begin
    if (q_w > SAT_HI)
      sat_w = SAT_HI[COORD_WIDTH-1:0];
    else if (q_w < SAT_LO)
      sat_w = SAT_LO[COORD_WIDTH-1:0];
    else
      sat_w = q_w[COORD_WIDTH-1:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r         <= '0;
      dst_r       <= DST_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl_i.start) t_r <= t_nxt;
      dst_r <= ctrl_i.dst;
      if (ctrl_i.emit)
        out_valid_r <= 1'b1;
      else if (out_ready_i)
        out_valid_r <= 1'b0;
    end
  end

  // multiplier product and writeback
  always_ff @(posedge clk) begin
    prod_r   <= prod_w;
    axis_d_r <= ctrl_i.axis;
    unique case (dst_r)
      DST_T2:        t2_r  <= rnd_q;
      DST_U2:        u2_r  <= rnd_q;
      DST_T3:        t3_r  <= rnd_q;
      DST_U3:        u3_r  <= rnd_q;
      DST_W1:        w1_r  <= rnd_x3;
      DST_W2:        w2_r  <= rnd_x3;
      DST_ACC_FIRST: acc_r <= ACC_W'(prod_r) + HALF_A;
      DST_ACC_ADD:   acc_r <= acc_sum;
      DST_ACC_LAST:  pos_r[axis_d_r] <= sat_w;
      default: ;
    endcase
    if (ctrl_i.emit) begin
      out_x_r <= pos_r[0];
      out_y_r <= pos_r[1];
      out_z_r <= pos_r[2];
      out_t_r <= t_r;
    end
  end

  assign out_free_o  = !out_valid_r || out_ready_i;
  assign out_valid_o = out_valid_r;
  assign pos_x_o     = out_x_r;
  assign pos_y_o     = out_y_r;
  assign pos_z_o     = out_z_r;
  assign param_o     = out_t_r;

endmodule

[hw/rtl/cubic_bezier_path_stepper.sv]
// ----------------------------------------------------------------------------
// cubic_bezier_path_stepper
// Steps a curve parameter and evaluates a 3D cubic Bezier point from four
// control points with one shared multiplier under microcode control.
//
//   channel  dir  handshake          payload
//   in_      in   tvalid/tready      tuser: cmd, tdata: new_param
//   out_     out  tvalid/tready      tdata: pos_x, pos_y, pos_z, param_out
//   cfg_     in   psel/penable/pwrite paddr 8*index, pwdata/prdata 64 bits
//
// an item runs from the accept cycle through the microcode program, in which
// the single multiplier issues 6 weight products and 12 coordinate products
// reset clears the parameter to 0, the step to 131 and the points to 0
// a finished result sits in the output register; the next item is taken while
// it waits, and the final step holds only while that register is still full
// ----------------------------------------------------------------------------
module cubic_bezier_path_stepper #(
  parameter int COORD_WIDTH     = 16,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // new_param
  input  logic [((PARAM_FRAC_BITS+3+7)/8)*8-1:0] in_tdata,
  // cmd
  input  logic                                   in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // pos_x, pos_y, pos_z, param_out
  output logic [((3*COORD_WIDTH+PARAM_FRAC_BITS+1+7)/8)*8-1:0] out_tdata,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [cbps_pkg::CFG_AW-1:0]            cfg_paddr,
  input  logic [cbps_pkg::CFG_DW-1:0]            cfg_pwdata,
  output logic [cbps_pkg::CFG_DW-1:0]            cfg_prdata,
  output logic                                   cfg_pready
);
  import cbps_pkg::*;

  localparam int PW     = PARAM_FRAC_BITS + 1;
  localparam int OUT_DW = ((3*COORD_WIDTH+PW+7)/8)*8;
  localparam logic [PW-1:0] ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};

  logic [3:0][PT_W-1:0]   points_w;
  logic [PW-1:0]          step_w;
  dp_ctrl_t               dp_ctrl;
  logic                   out_free;
  logic [COORD_WIDTH-1:0] pos_x_w, pos_y_w, pos_z_w;
  logic [PW-1:0]          param_w;

  cbps_cfg_regs #(
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .points_o    (points_w),
    .step_o      (step_w)
  );

  cbps_useq u_useq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_tvalid),
    .in_ready_o (in_tready),
    .out_free_i (out_free),
    .ctrl_o     (dp_ctrl)
  );

  cbps_datapath #(
    .COORD_WIDTH     (COORD_WIDTH),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl_i      (dp_ctrl),
    .cmd_i       (in_tuser),
    .new_param_i (in_tdata[PARAM_FRAC_BITS+2:0]),
    .points_i    (points_w),
    .step_i      (step_w),
    .out_ready_i (out_tready),
    .out_valid_o (out_tvalid),
    .out_free_o  (out_free),
    .pos_x_o     (pos_x_w),
    .pos_y_o     (pos_y_w),
    .pos_z_o     (pos_z_w),
    .param_o     (param_w)
  );

  assign out_tdata = OUT_DW'({param_w, pos_z_w, pos_y_w, pos_x_w});

`ifndef SYNTHESIS
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    dp_ctrl.emit |-> (!out_tvalid || out_tready))
    else $error("result emitted over an untaken result");

  a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (param_w <= ONE))
    else $error("curve parameter above one");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second transaction taken while evaluating");
`endif

endmodule
